@@ src/binary_3x3_lut_morphology_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 lookup-table filter.
// Each macro checks one property on the rising edge of clk while rst_n is high.
// ----------------------------------------------------------------------------
`ifndef BINARY_3X3_LUT_MORPHOLOGY_TOP_MACROS_SVH
`define BINARY_3X3_LUT_MORPHOLOGY_TOP_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define B3LM_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("binary_3x3_lut_morphology_top: assertion failed");

// The property must hold in the cycle after the condition.
`define B3LM_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("binary_3x3_lut_morphology_top: assertion failed");

`endif

@@ src/b3lm_pkg.sv @@
// ----------------------------------------------------------------------------
// b3lm_pkg
// Shared constants, types and window helpers for the 3x3 lookup-table filter.
// ----------------------------------------------------------------------------
package b3lm_pkg;

    localparam int MAX_COLS_DEFAULT = 1024;
    localparam int TABLE_ENTRIES    = 512;
    localparam int TABLE_REG_W      = 64;
    localparam int CFG_INDEX_W      = 3;
    localparam int NUM_BANKS        = 3;
    localparam int BANK_W           = 2;
    localparam int WIN_W            = 9;
    localparam int ROW_CNT_W        = 2;
    localparam int RES_CNT_W        = 2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef logic [WIN_W-1:0] win_t;

    typedef struct packed {
        logic pix;
        logic row_end;
        logic frame_end;
        logic run_last;
        logic size_error;
    } result_t;

    typedef struct packed {
        logic               drain;
        logic               pix;
        logic               eff0;
        logic               ending;
        logic               rc_nz;
        logic               rc_z;
        logic               first;
        logic               last;
        logic               err;
        logic [RES_CNT_W-1:0] n;
        logic [BANK_W-1:0]  bank_a;
        logic [BANK_W-1:0]  bank_b;
    } stage_t;

    function automatic logic [BANK_W-1:0] bank_next(input logic [BANK_W-1:0] b);
        logic [BANK_W-1:0] r;
        case (b)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [BANK_W-1:0] bank_prev(input logic [BANK_W-1:0] b);
        logic [BANK_W-1:0] r;
        case (b)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    // Window bits: top row in 0..2, middle in 3..5, bottom in 6..8, left to right.
    function automatic win_t win_fill(input logic t, input logic m, input logic b);
        return {b, b, b, m, m, m, t, t, t};
    endfunction

    function automatic win_t win_shift(input win_t w, input logic t, input logic m,
                                       input logic b);
        return {b, w[8:7], m, w[5:4], t, w[2:1]};
    endfunction

endpackage

@@ src/binary_3x3_lut_morphology_top.sv @@
// ----------------------------------------------------------------------------
// Binary 3x3 lookup-table filter: a request is registered in stage s1, its result in res0.
// One request per cycle while in_stall is low; a row-end pixel can stall the input.
// Reset clears all control state and the table; the line memory is not cleared.
// ----------------------------------------------------------------------------
`include "binary_3x3_lut_morphology_top_macros.svh"

module binary_3x3_lut_morphology_top #(
    parameter int MAX_COLS = b3lm_pkg::MAX_COLS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [b3lm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [b3lm_pkg::TABLE_REG_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic                                pixel_in,
    input  logic                                row_end_in,
    input  logic                                frame_end_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pixel_out,
    output logic                                row_end_out,
    output logic                                frame_end_out,
    output logic                                run_last,
    output logic                                size_error
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int AW = $clog2(MAX_COLS);
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_COLS);
    localparam logic [CW-1:0] LAST_C = CW'(MAX_COLS - 1);

    logic [b3lm_pkg::TABLE_ENTRIES-1:0] table_reg;

    logic [CW-1:0]                    col_reg, col_next;
    logic [CW-1:0]                    lw_reg, lw_next;
    logic [CW-1:0]                    drain_reg, drain_next;
    logic [b3lm_pkg::ROW_CNT_W-1:0]   row_reg, row_next;
    logic [b3lm_pkg::BANK_W-1:0]      sel_reg, sel_next;
    logic                             err_reg, err_next;
    logic [CW-1:0]                    buf_len_reg [0:b3lm_pkg::NUM_BANKS-1];
    logic                             len_wr_en;

    b3lm_pkg::stage_t                 s1_reg, s1_next;
    logic                             s1_valid_reg, s1_valid_next;
    logic                             s1_move;

    logic                             in_fire, out_fire;
    logic                             pend, fstart, ending, sat;
    logic [CW-1:0]                    cc, lw_cur, len, drain_rcol, rd_col;
    logic [CW:0]                      cc_inc;
    logic [b3lm_pkg::ROW_CNT_W-1:0]   rc;
    logic [AW-1:0]                    eff, addr_a, addr_b;
    logic [AW-1:0]                    rd_addr [0:b3lm_pkg::NUM_BANKS-1];
    logic [b3lm_pkg::BANK_W-1:0]      prev_bank, next_bank, px_top, dr_top;
    logic [b3lm_pkg::BANK_W-1:0]      bank_a, bank_b;
    logic                             err_px, wr_en;

    logic                             line_mem [0:b3lm_pkg::NUM_BANKS-1][0:MAX_COLS-1];
    logic                             rd_reg [0:b3lm_pkg::NUM_BANKS-1];

    b3lm_pkg::win_t                   w_reg, w_next, w_a, w_b, w_d;
    logic                             cap_top0_reg, cap_top0_next;
    logic                             cap_mid0_reg, cap_mid0_next;
    logic                             t_bit, m_bit;

    b3lm_pkg::result_t                res0_reg, res1_reg, res0_next, res1_next;
    b3lm_pkg::result_t                r_mid, r_end, r_drain;
    logic [b3lm_pkg::RES_CNT_W-1:0]   res_cnt_reg, res_cnt_next;

    logic [CW:0]                      drain_span, sel_len_x;

    function automatic logic [AW-1:0] clamp_col(input logic [CW-1:0] col,
                                                input logic [CW-1:0] blen);
        logic [CW-1:0] c;
        c = col;
        if ((blen != '0) && (c >= blen)) c = blen - CW'(1);
        if (c > LAST_C) c = LAST_C;
        return c[AW-1:0];
    endfunction

    assign in_fire  = in_valid && !in_stall;
    assign out_valid = (res_cnt_reg != '0);
    assign out_fire = out_valid && !out_stall;

    assign s1_move  = s1_valid_reg && ((s1_reg.n == '0) || (res_cnt_reg == '0) ||
                      ((res_cnt_reg == 2'd1) && out_fire));
    assign in_stall = s1_valid_reg && !s1_move;

    always_comb
    begin
        pend      = (drain_reg != '0);
        cc        = pend ? '0 : col_reg;
        rc        = pend ? '0 : row_reg;
        fstart    = (rc == '0) && (cc == '0);
        ending    = row_end_in | frame_end_in;
        sat       = (cc >= MAX_C);
        eff       = sat ? LAST_C[AW-1:0] : cc[AW-1:0];
        len       = CW'(eff) + CW'(1);
        cc_inc    = {1'b0, cc} + {{CW{1'b0}}, 1'b1};
        lw_cur    = fstart ? '0 : lw_reg;
        prev_bank = b3lm_pkg::bank_prev(sel_reg);
        next_bank = b3lm_pkg::bank_next(sel_reg);
        px_top    = (rc == 2'd1) ? prev_bank : next_bank;
        dr_top    = (row_reg == '0) ? sel_reg : prev_bank;
        drain_rcol = col_reg + CW'(1);
        err_px    = (fstart ? 1'b0 : err_reg) | sat |
                    ((rc != '0) && (cc >= lw_cur)) |
                    (ending && (fstart || ((rc != '0) && (cc_inc < {1'b0, lw_cur})) ||
                                (frame_end_in && (rc == '0))));

        if (req_type == b3lm_pkg::REQ_DRAIN)
        begin
            bank_a = dr_top;
            bank_b = sel_reg;
            rd_col = drain_rcol;
        end
        else
        begin
            bank_a = px_top;
            bank_b = prev_bank;
            rd_col = CW'(eff);
        end
        addr_a = clamp_col(rd_col, buf_len_reg[bank_a]);
        addr_b = clamp_col(rd_col, buf_len_reg[bank_b]);
        for (int b = 0; b < b3lm_pkg::NUM_BANKS; b++)
        begin
            rd_addr[b] = (bank_a == b3lm_pkg::BANK_W'(b)) ? addr_a : addr_b;
        end

        col_next   = col_reg;
        lw_next    = lw_reg;
        drain_next = drain_reg;
        row_next   = row_reg;
        sel_next   = sel_reg;
        err_next   = err_reg;
        len_wr_en  = 1'b0;
        wr_en      = 1'b0;
        s1_next    = s1_reg;
        s1_valid_next = s1_move ? 1'b0 : s1_valid_reg;

        if (in_fire)
        begin
            s1_next.drain  = req_type;
            s1_next.pix    = pixel_in;
            s1_next.bank_a = bank_a;
            s1_next.bank_b = bank_b;
            if (req_type == b3lm_pkg::REQ_DRAIN)
            begin
                s1_valid_next  = pend;
                s1_next.eff0   = 1'b0;
                s1_next.ending = 1'b0;
                s1_next.rc_nz  = 1'b0;
                s1_next.rc_z   = 1'b0;
                s1_next.first  = (col_reg == '0);
                s1_next.last   = (drain_reg == CW'(1));
                s1_next.err    = err_reg;
                s1_next.n      = 2'd1;
                if (pend)
                begin
                    drain_next = drain_reg - CW'(1);
                    col_next   = (col_reg < MAX_C) ? col_reg + CW'(1) : col_reg;
                    if (drain_reg == CW'(1))
                    begin
                        row_next = '0;
                        col_next = '0;
                    end
                end
            end
            else
            begin
                s1_valid_next  = 1'b1;
                wr_en          = 1'b1;
                s1_next.eff0   = (eff == '0);
                s1_next.ending = ending;
                s1_next.rc_nz  = (rc != '0);
                s1_next.rc_z   = (rc == '0);
                s1_next.first  = 1'b0;
                s1_next.last   = 1'b0;
                s1_next.err    = err_px;
                s1_next.n      = (rc != '0) ? ({1'b0, (eff != '0)} + {1'b0, ending}) : '0;
                err_next   = err_px;
                drain_next = '0;
                row_next   = rc;
                lw_next    = lw_cur;
                if (ending)
                begin
                    len_wr_en = 1'b1;
                    col_next  = '0;
                    if (rc == '0) lw_next = len;
                    if (frame_end_in)
                    begin
                        drain_next = len;
                    end
                    else
                    begin
                        sel_next = next_bank;
                        row_next = (rc == 2'd2) ? rc : rc + 2'd1;
                    end
                end
                else
                begin
                    col_next = sat ? cc : cc + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg    <= '0;
            col_reg      <= '0;
            lw_reg       <= '0;
            drain_reg    <= '0;
            row_reg      <= '0;
            sel_reg      <= '0;
            err_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            for (int b = 0; b < b3lm_pkg::NUM_BANKS; b++)
            begin
                buf_len_reg[b] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                table_reg[{cfg_index, 6'd0} +: b3lm_pkg::TABLE_REG_W] <= cfg_data;
            end
            col_reg      <= col_next;
            lw_reg       <= lw_next;
            drain_reg    <= drain_next;
            row_reg      <= row_next;
            sel_reg      <= sel_next;
            err_reg      <= err_next;
            s1_valid_reg <= s1_valid_next;
            if (len_wr_en)
            begin
                buf_len_reg[sel_reg] <= len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        if (wr_en)
        begin
            line_mem[sel_reg][eff] <= pixel_in;
        end
        if (in_fire)
        begin
            rd_reg[0] <= line_mem[0][rd_addr[0]];
            rd_reg[1] <= line_mem[1][rd_addr[1]];
            rd_reg[2] <= line_mem[2][rd_addr[2]];
        end
    end

    always_comb
    begin
        t_bit = rd_reg[s1_reg.bank_a];
        m_bit = rd_reg[s1_reg.bank_b];

        w_a = s1_reg.eff0 ? b3lm_pkg::win_fill(t_bit, m_bit, s1_reg.pix)
                          : b3lm_pkg::win_shift(w_reg, t_bit, m_bit, s1_reg.pix);
        w_b = b3lm_pkg::win_shift(w_a, w_a[2], w_a[5], w_a[8]);
        w_d = b3lm_pkg::win_shift(s1_reg.first
                  ? b3lm_pkg::win_fill(cap_top0_reg, cap_mid0_reg, cap_mid0_reg)
                  : w_reg, t_bit, m_bit, m_bit);

        r_mid   = '{pix: table_reg[w_a], row_end: 1'b0, frame_end: 1'b0,
                    run_last: !s1_reg.ending, size_error: s1_reg.err};
        r_end   = '{pix: table_reg[w_b], row_end: 1'b1, frame_end: 1'b0,
                    run_last: 1'b1, size_error: s1_reg.err};
        r_drain = '{pix: table_reg[w_d], row_end: s1_reg.last, frame_end: s1_reg.last,
                    run_last: 1'b1, size_error: s1_reg.err};

        w_next        = w_reg;
        cap_top0_next = cap_top0_reg;
        cap_mid0_next = cap_mid0_reg;
        res0_next     = res0_reg;
        res1_next     = res1_reg;
        res_cnt_next  = res_cnt_reg;

        if (out_fire)
        begin
            res0_next    = res1_reg;
            res_cnt_next = res_cnt_reg - 2'd1;
        end

        if (s1_move)
        begin
            if (s1_reg.drain)
            begin
                w_next = w_d;
                res0_next = r_drain;
            end
            else
            begin
                if (s1_reg.eff0)
                begin
                    cap_top0_next = s1_reg.rc_z ? s1_reg.pix : m_bit;
                    cap_mid0_next = s1_reg.pix;
                end
                if (s1_reg.rc_nz)
                begin
                    w_next = s1_reg.ending ? w_b : w_a;
                end
                if (s1_reg.eff0)
                begin
                    res0_next = r_end;
                end
                else
                begin
                    res0_next = r_mid;
                    res1_next = r_end;
                end
            end
            if (s1_reg.n != '0)
            begin
                res_cnt_next = s1_reg.n;
            end
            else
            begin
                res0_next = out_fire ? res1_reg : res0_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= '0;
            cap_top0_reg <= 1'b0;
            cap_mid0_reg <= 1'b0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            w_reg        <= w_next;
            cap_top0_reg <= cap_top0_next;
            cap_mid0_reg <= cap_mid0_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    assign pixel_out     = res0_reg.pix;
    assign row_end_out   = res0_reg.row_end;
    assign frame_end_out = res0_reg.frame_end;
    assign run_last      = res0_reg.run_last;
    assign size_error    = res0_reg.size_error;

    assign drain_span = {1'b0, col_reg} + {1'b0, drain_reg};
    assign sel_len_x  = {1'b0, buf_len_reg[sel_reg]};

    // While a last row drains, the columns done plus those left cover the stored row.
    `B3LM_ASSERT_IMP(a_drain_span, drain_reg != '0, drain_span == sel_len_x)
    `B3LM_ASSERT_NXT(a_res_load, s1_move && (s1_reg.n != '0), res_cnt_reg == $past(s1_reg.n))
    `B3LM_ASSERT_IMP(a_two_results, s1_valid_reg && (s1_reg.n == 2'd2), !s1_reg.drain && s1_reg.ending && !s1_reg.eff0)

endmodule
